// ----- hw/rtl/rqps_pkg.sv -----
// Shared types, codes and sizes for the ready queue policy selector.
// Used by rqps_entry_ram, rqps_rank and ready_queue_policy_selector.
package rqps_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef logic [2:0] policy_type;
   localparam policy_type POLICY_RR   = 3'd0;
   localparam policy_type POLICY_SJF  = 3'd1;
   localparam policy_type POLICY_SRT  = 3'd2;
   localparam policy_type POLICY_GRT  = 3'd3;
   localparam policy_type POLICY_PRIO = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_ENQUEUED   = 2'd0;
   localparam status_type STATUS_DISPATCHED = 2'd1;
   localparam status_type STATUS_EMPTY      = 2'd2;
   localparam status_type STATUS_FULL       = 2'd3;

   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef struct packed {
      logic [7:0]         id;
      logic [15:0]        target;
      logic [15:0]        served;
      logic signed [15:0] prio;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ----- hw/rtl/rqps_entry_ram.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on rqps_pkg for the entry type and depth.
module rqps_entry_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [rqps_pkg::IDX_W-1:0]   wr_addr,
   input  rqps_pkg::entry_type          wr_data,
   input  logic [rqps_pkg::IDX_W-1:0]   rd_addr,
   output rqps_pkg::entry_type          rd_data
);

   rqps_pkg::entry_type mem [rqps_pkg::MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/rqps_rank.sv -----
// Policy comparator: says whether a candidate entry beats the current best.
// Depends on rqps_pkg for the entry type and policy codes.
module rqps_rank (
   input  rqps_pkg::policy_type policy,
   input  rqps_pkg::entry_type  cand,
   input  rqps_pkg::entry_type  best,
   output logic                 take
);

   logic signed [16:0] rem_cand;
   logic signed [16:0] rem_best;
   logic [31:0]        prod_cand;
   logic [31:0]        prod_best;

   always_comb begin
      rem_cand  = $signed({1'b0, cand.target}) - $signed({1'b0, cand.served});
      rem_best  = $signed({1'b0, best.target}) - $signed({1'b0, best.served});
      // served/target ratios, cross-multiplied
      prod_cand = {16'd0, cand.served} * {16'd0, best.target};
      prod_best = {16'd0, best.served} * {16'd0, cand.target};
      case (policy)
         rqps_pkg::POLICY_SJF:  take = cand.target < best.target;
         rqps_pkg::POLICY_SRT:  take = rem_cand < rem_best;
         rqps_pkg::POLICY_GRT:  take = prod_cand < prod_best;
         rqps_pkg::POLICY_PRIO: take = cand.prio > best.prio;
         default:               take = 1'b0;
      endcase
   end

endmodule

// ----- hw/rtl/ready_queue_policy_selector.sv -----
// Ready queue with selectable dispatch policy: control, scan and compaction.
// Depends on rqps_pkg, rqps_entry_ram and rqps_rank.
//
// Input channel req_*: req_tuser is the operation (enqueue or dispatch),
// req_tdata carries the entry fields. Every input transfer gives exactly
// one result transfer on rsp_*: rsp_tuser is the status, rsp_tdata the
// dispatched id and the occupancy after the item.
// The policy register is written through csr_wr_en/csr_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// An enqueue, or a dispatch on an empty queue, has its result registered
// with the done state, then moved to the output register. A dispatch over
// n entries reads the entry memory once per cycle to pick the winner, then
// moves each entry behind the winner down one slot, then posts the result.
// One item is worked on at a time; req_tready is high while the
// control sequencer is idle, even if a result still waits on rsp_*.
// If the receiver stalls, a finished result waits in the sequencer until
// the output register frees. Synchronous reset empties the queue, drops
// any pending result and selects round robin; memory contents are kept,
// and only entries below the fill count are ever read.
module ready_queue_policy_selector (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = operation
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // proc_id[7:0], target_time[23:8],
                                   // served_time[39:24], priority_req[55:40]
   input  logic [0:0]  req_tuser,  // operation[0]
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // selected_id[7:0], occupancy[12:8], zero pad
   output logic [1:0]  rsp_tuser,  // status[1:0]
   // policy register
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam int IDX_W = rqps_pkg::IDX_W;
   localparam int CNT_W = rqps_pkg::CNT_W;

   rqps_pkg::state_type  state_ff, state_in;
   rqps_pkg::policy_type policy_ff, policy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     last_ff, last_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   rqps_pkg::entry_type  best_ff, best_in;
   rqps_pkg::status_type res_status_ff, res_status_in;
   logic [7:0]           res_id_ff, res_id_in;
   logic [4:0]           res_occ_ff, res_occ_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rqps_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_id_ff, rsp_id_in;
   logic [4:0]           rsp_occ_ff, rsp_occ_in;

   rqps_pkg::entry_type  req_entry;
   rqps_pkg::entry_type  rd_data;
   rqps_pkg::entry_type  wr_data;
   rqps_pkg::entry_type  sel_entry;
   logic [IDX_W-1:0]     sel_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   logic                 wr_en;
   logic                 take;

   assign req_entry.id     = req_tdata[7:0];
   assign req_entry.target = req_tdata[23:8];
   assign req_entry.served = req_tdata[39:24];
   assign req_entry.prio   = req_tdata[55:40];

   rqps_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rqps_rank u_rank (
      .policy (policy_ff),
      .cand   (rd_data),
      .best   (best_ff),
      .take   (take)
   );

   assign req_tready = (state_ff == rqps_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_id_ff};

   // winner so far, including the entry whose read data arrives this cycle
   always_comb begin
      if ((cmp_idx_ff == '0) || take) begin
         sel_entry = rd_data;
         sel_idx   = cmp_idx_ff;
      end else begin
         sel_entry = best_ff;
         sel_idx   = best_idx_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      cmp_idx_in    = cmp_idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_occ_in    = res_occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = req_entry;
      rd_addr       = '0;

      if (csr_wr_en) begin
         policy_in = csr_wr_data;
      end

      case (state_ff)
         rqps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               res_id_in = 8'd0;
               state_in  = rqps_pkg::ST_DONE;
               if (req_tuser[0] == rqps_pkg::OP_ENQUEUE) begin
                  if (count_ff == CNT_W'(rqps_pkg::MAX_ENTRIES)) begin
                     res_status_in = rqps_pkg::STATUS_FULL;
                     res_occ_in    = 5'(count_ff);
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = rqps_pkg::STATUS_ENQUEUED;
                     res_occ_in    = 5'(count_ff + CNT_W'(1));
                  end
               end else if (count_ff == '0) begin
                  res_status_in = rqps_pkg::STATUS_EMPTY;
                  res_occ_in    = 5'd0;
               end else begin
                  // start the scan at the head; the count drops now
                  count_in      = count_ff - CNT_W'(1);
                  last_in       = IDX_W'(count_ff - CNT_W'(1));
                  res_status_in = rqps_pkg::STATUS_DISPATCHED;
                  res_occ_in    = 5'(count_ff - CNT_W'(1));
                  cmp_idx_in    = '0;
                  rd_addr       = '0;
                  state_in      = rqps_pkg::ST_SCAN;
               end
            end
         end
         rqps_pkg::ST_SCAN: begin
            best_in     = sel_entry;
            best_idx_in = sel_idx;
            if (cmp_idx_ff == last_ff) begin
               res_id_in = sel_entry.id;
               if (sel_idx == last_ff) begin
                  state_in = rqps_pkg::ST_DONE;
               end else begin
                  // close the gap: read the entry behind the winner
                  rd_addr   = sel_idx + IDX_W'(1);
                  wr_ptr_in = sel_idx;
                  state_in  = rqps_pkg::ST_SHIFT;
               end
            end else begin
               rd_addr    = cmp_idx_ff + IDX_W'(1);
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         rqps_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wr_ptr_ff;
            wr_data = rd_data;
            if ((wr_ptr_ff + IDX_W'(1)) == last_ff) begin
               state_in = rqps_pkg::ST_DONE;
            end else begin
               rd_addr   = wr_ptr_ff + IDX_W'(2);
               wr_ptr_in = wr_ptr_ff + IDX_W'(1);
            end
         end
         rqps_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_occ_in    = res_occ_ff;
               state_in      = rqps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqps_pkg::ST_IDLE;
         policy_ff    <= rqps_pkg::POLICY_RR;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      cmp_idx_ff    <= cmp_idx_in;
      wr_ptr_ff     <= wr_ptr_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_occ_ff    <= res_occ_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

endmodule

// ----- verif/ready_queue_policy_selector_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ready_queue_policy_selector: directed rows, then random traffic
// under every policy code, checked against a behavioral ready-queue model.
// Depends on rqps_pkg and the ready_queue_policy_selector RTL.
module ready_queue_policy_selector_tb;
   import rqps_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 55;
   localparam int PHASE_COUNT = 12;
   localparam int DIR_ROW_COUNT = 19;

   // codes the block has no name for; they must behave as round robin
   localparam policy_type POLICY_UNUSED_5 = 3'd5;
   localparam policy_type POLICY_UNUSED_6 = 3'd6;
   localparam policy_type POLICY_UNUSED_7 = 3'd7;

   typedef struct packed {
      status_type status;
      logic [7:0] sel_id;
      logic [4:0] occupancy;
   } result_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  id;
      logic [15:0] target;
      logic [15:0] served;
      logic [15:0] prio;
      policy_type  pol;
      logic [4:0]  rep;
      logic        typed;
      status_type  st;
      logic [7:0]  sid;
      logic [4:0]  occ;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;  // proc_id[7:0], target_time[23:8], served_time[39:24],
                            // priority_req[55:40]
   logic [0:0]  req_tuser;  // operation[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;  // selected_id[7:0], occupancy[12:8], zero pad[15:13]
   logic [1:0]  rsp_tuser;  // status[1:0]
   logic        csr_wr_en;
   logic [2:0]  csr_wr_data;

   // expectation typed into a directed row travels with the request
   logic       row_typed;
   result_type row_result;

   entry_type  ready_model[$];
   policy_type model_policy;
   result_type pending_results[$];
   int         mismatch_count = 0;
   bit         send_gaps = 1'b1;
   bit         rsp_gaps = 1'b1;
   int         rsp_hold_cycles = 0;

   // op, id, target, served, prio, policy, repeat, typed, status, id, occupancy
   stim_row_type dir_rows [DIR_ROW_COUNT] = '{
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_RR, 5'd1, 1'b1,
        STATUS_EMPTY, 8'h00, 5'd0},
      '{OP_ENQUEUE, 8'h00, 16'h0001, 16'h0000, 16'h8000, POLICY_RR, 5'd1, 1'b1,
        STATUS_ENQUEUED, 8'h00, 5'd1},
      '{OP_ENQUEUE, 8'hff, 16'hffff, 16'hffff, 16'h7fff, POLICY_RR, 5'd1, 1'b1,
        STATUS_ENQUEUED, 8'h00, 5'd2},
      // zero over zero ratio
      '{OP_ENQUEUE, 8'h5a, 16'h0000, 16'h0000, 16'h0000, POLICY_RR, 5'd1, 1'b1,
        STATUS_ENQUEUED, 8'h00, 5'd3},
      // served over zero target: infinite ratio
      '{OP_ENQUEUE, 8'ha5, 16'h0000, 16'h0007, 16'h0001, POLICY_RR, 5'd1, 1'b1,
        STATUS_ENQUEUED, 8'h00, 5'd4},
      // served above target: negative remaining time
      '{OP_ENQUEUE, 8'h3c, 16'd10, 16'd40, 16'hffff, POLICY_RR, 5'd1, 1'b1,
        STATUS_ENQUEUED, 8'h00, 5'd5},
      // identical entries, ids differ: ties go to the earliest
      '{OP_ENQUEUE, 8'h10, 16'd200, 16'd50, 16'd5, POLICY_RR, 5'd11, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_ENQUEUE, 8'h77, 16'd5, 16'd0, 16'd0, POLICY_RR, 5'd1, 1'b1,
        STATUS_FULL, 8'h00, 5'd16},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_RR, 5'd1, 1'b1,
        STATUS_DISPATCHED, 8'h00, 5'd15},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_SJF, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_SRT, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_GRT, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_PRIO, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_UNUSED_5, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_UNUSED_6, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_UNUSED_7, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_ENQUEUE, 8'h81, 16'h0001, 16'h0001, 16'h8000, POLICY_UNUSED_7, 5'd1, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'hffff, 16'hffff, 16'hffff, POLICY_PRIO, 5'd9, 1'b0,
        STATUS_ENQUEUED, 8'h00, 5'd0},
      '{OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 16'h0000, POLICY_PRIO, 5'd1, 1'b1,
        STATUS_EMPTY, 8'h00, 5'd0}
   };

   policy_type phase_plan [PHASE_COUNT] = '{
      POLICY_RR, POLICY_SJF, POLICY_SRT, POLICY_GRT, POLICY_PRIO, POLICY_UNUSED_7,
      POLICY_GRT, POLICY_UNUSED_5, POLICY_UNUSED_6, POLICY_SRT, POLICY_PRIO, POLICY_SJF
   };

   ready_queue_policy_selector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Apply one accepted item to the queue model and return the result it must produce.
   function automatic result_type apply_item(input logic op, input entry_type e);
      result_type r;
      int         best;
      int         i;
      logic       take;
      r = '0;
      if (op == OP_ENQUEUE) begin
         if (ready_model.size() >= MAX_ENTRIES) begin
            r.status = STATUS_FULL;
         end else begin
            ready_model.push_back(e);
            r.status = STATUS_ENQUEUED;
         end
      end else if (ready_model.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         best = 0;
         for (i = 1; i < ready_model.size(); i++) begin
            // strict compare: the earliest entry keeps a tie
            case (model_policy)
               POLICY_SJF: take = ready_model[i].target < ready_model[best].target;
               POLICY_SRT: take = (int'(ready_model[i].target) - int'(ready_model[i].served)) <
                                  (int'(ready_model[best].target) -
                                   int'(ready_model[best].served));
               POLICY_GRT: take = ({16'd0, ready_model[i].served} *
                                   {16'd0, ready_model[best].target}) <
                                  ({16'd0, ready_model[best].served} *
                                   {16'd0, ready_model[i].target});
               POLICY_PRIO: take = ready_model[i].prio > ready_model[best].prio;
               default: take = 1'b0;
            endcase
            if (take) begin
               best = i;
            end
         end
         r.status = STATUS_DISPATCHED;
         r.sel_id = ready_model[best].id;
         ready_model.delete(best);
      end
      r.occupancy = 5'(ready_model.size());
      return r;
   endfunction

   always @(posedge clock) begin : result_check
      result_type want;
      entry_type  e;
      if (reset) begin
         ready_model.delete();
         model_policy = POLICY_RR;
      end else begin
         if (csr_wr_en) begin
            model_policy = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("result transfer with nothing pending, status %0d",
                                       rsp_tuser));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status)
                  flag_mismatch($sformatf("status got %0d want %0d", rsp_tuser, want.status));
               if (rsp_tdata[7:0] !== want.sel_id)
                  flag_mismatch($sformatf("selected_id got %0h want %0h",
                                          rsp_tdata[7:0], want.sel_id));
               if (rsp_tdata[12:8] !== want.occupancy)
                  flag_mismatch($sformatf("occupancy got %0d want %0d",
                                          rsp_tdata[12:8], want.occupancy));
               if (rsp_tdata[15:13] !== 3'b000)
                  flag_mismatch($sformatf("pad bits got %0h", rsp_tdata[15:13]));
            end
         end
         if (req_tvalid && req_tready) begin
            e.id     = req_tdata[7:0];
            e.target = req_tdata[23:8];
            e.served = req_tdata[39:24];
            e.prio   = req_tdata[55:40];
            want = apply_item(req_tuser[0], e);
            if (row_typed) begin
               want = row_result;
            end
            pending_results.push_back(want);
         end
      end
   end

   // Offer one item until taken; valid stays up for a follow-on item unless a gap is drawn.
   task automatic send_item(input logic op, input entry_type e, input logic typed,
                            input result_type want);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {e.prio, e.served, e.target, e.id};
      row_typed  <= typed;
      row_result <= want;
      do @(posedge clock); while (!req_tready);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Stop offering, let every pending result arrive, then let the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(input policy_type p);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            // long hold-off: the block must fill up and stall its input
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      policy_type cur_policy;
      entry_type  e;
      result_type want;
      logic       op;
      int         k;
      int         n;
      int         phase;
      int         enq_pct;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      row_typed   <= 1'b0;
      row_result  <= '0;
      cur_policy  = POLICY_RR;
      enq_pct     = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROW_COUNT; k++) begin
         if (dir_rows[k].pol != cur_policy) begin
            wait_idle();
            write_policy(dir_rows[k].pol);
            cur_policy = dir_rows[k].pol;
         end
         for (n = 0; n < dir_rows[k].rep; n++) begin
            e.id     = dir_rows[k].id + 8'(n);
            e.target = dir_rows[k].target;
            e.served = dir_rows[k].served;
            e.prio   = dir_rows[k].prio;
            want     = '{dir_rows[k].st, dir_rows[k].sid, dir_rows[k].occ};
            send_item(dir_rows[k].op, e, dir_rows[k].typed, want);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         write_policy(phase_plan[phase]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) begin
               case ($urandom_range(0, 3))
                  0: enq_pct = 35;
                  1: enq_pct = 50;
                  2: enq_pct = 65;
                  default: enq_pct = 85;
               endcase
               // quiet stretches now and then; none in the closing phase
               send_gaps = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 2) != 0);
               rsp_gaps  = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 2) != 0);
            end
            if (phase == 2 && n == 20) begin
               rsp_hold_cycles = LONG_HOLD_CYCLES;
            end
            if (phase == 4 && n == 30) begin
               wait_idle();
            end
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH;
            e.id = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
               0: e.target = 16'h0000;
               1: e.target = 16'hffff;
               2, 3: e.target = 16'($urandom);
               default: e.target = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
               0: e.served = 16'h0000;
               1: e.served = 16'hffff;
               2, 3: e.served = 16'($urandom);
               default: e.served = 16'($urandom_range(0, 14));
            endcase
            case ($urandom_range(0, 9))
               0: e.prio = 16'h8000;
               1: e.prio = 16'h7fff;
               2, 3: e.prio = 16'($urandom);
               default: e.prio = 16'($urandom_range(0, 6)) - 16'd3;
            endcase
            send_item(op, e, 1'b0, '0);
         end
      end

      wait_idle();
      if (pending_results.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("ready_queue_policy_selector_tb passed");
      end else begin
         $display("ready_queue_policy_selector_tb failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TIMEOUT at %0t", $time);
      $display("ready_queue_policy_selector_tb failed");
      $finish;
   end

endmodule
